@@ rtl/tgt_pkg.sv @@
// Shared types and constants for the two-point gesture tracker.
// Holds the queued frame record, frame kind codes and the CORDIC tables.
// No dependencies.
package tgt_pkg;

    localparam int COORD_W = 10;
    localparam int SUM_W   = 11;
    localparam int DELTA_W = 11;
    localparam int DIST_W  = 15;
    localparam int ANG_W   = 16;
    localparam int AXIS_W  = 16;

    localparam logic [1:0] KIND_IDLE    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_LATCH   = 2'd2;
    localparam logic [1:0] KIND_TRACK   = 2'd3;

    localparam int XW       = 30;
    localparam int ZW       = 35;
    localparam int ATAN_W   = 30;
    localparam int INVK_W   = 30;
    localparam int PRE_SHIFT = 16;

    localparam logic signed [ZW-1:0]  PI_Q30   = 35'sd3373259426;
    localparam logic [INVK_W-1:0]     INVK_Q30 = 30'd652032874;

    typedef struct packed {
        logic                       touch;
        logic                       changed;
        logic [1:0]                 kind;
        logic [SUM_W-1:0]           sum_x;
        logic [SUM_W-1:0]           sum_y;
        logic signed [DELTA_W-1:0]  dx;
        logic signed [DELTA_W-1:0]  dy;
    } frame_t;

    function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 30'h3243F6A8;
                5'd1:    v = 30'h1DAC6705;
                5'd2:    v = 30'h0FADBAFC;
                5'd3:    v = 30'h07F56EA6;
                5'd4:    v = 30'h03FEAB76;
                5'd5:    v = 30'h01FFD55B;
                5'd6:    v = 30'h00FFFAAA;
                5'd7:    v = 30'h007FFF55;
                5'd8:    v = 30'h003FFFEA;
                5'd9:    v = 30'h001FFFFD;
                5'd10:   v = 30'h000FFFFF;
                5'd11:   v = 30'h0007FFFF;
                5'd12:   v = 30'h0003FFFF;
                5'd13:   v = 30'h0001FFFF;
                5'd14:   v = 30'h0000FFFF;
                5'd15:   v = 30'h00007FFF;
                5'd16:   v = 30'h00003FFF;
                5'd17:   v = 30'h00001FFF;
                5'd18:   v = 30'h00000FFF;
                5'd19:   v = 30'h000007FF;
                5'd20:   v = 30'h000003FF;
                5'd21:   v = 30'h000001FF;
                5'd22:   v = 30'h000000FF;
                5'd23:   v = 30'h0000007F;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/tgt_front.sv @@
// Front end of the gesture tracker: accepts camera frames and classifies them.
// Tracks touch and start-latch state and pushes frame records to the queue.
// Depends on tgt_pkg.
module tgt_front
    import tgt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [39:0] in_data,
    input  logic [1:0]  in_user,
    input  logic        queue_full,
    output logic        push,
    output frame_t      item
);

    logic                prev_touch_reg;
    logic                prev_touch_next;
    logic                latched_reg;
    logic                latched_next;
    logic [COORD_W-1:0]  x1;
    logic [COORD_W-1:0]  y1;
    logic [COORD_W-1:0]  x2;
    logic [COORD_W-1:0]  y2;
    logic                touch;
    logic                changed;

    always_comb
    begin
        x1 = in_data[9:0];
        y1 = in_data[19:10];
        x2 = in_data[29:20];
        y2 = in_data[39:30];
        touch   = in_user[0] & in_user[1];
        changed = touch ^ prev_touch_reg;

        item.touch   = touch;
        item.changed = changed;
        if (!touch)
        begin
            item.kind = changed ? KIND_RELEASE : KIND_IDLE;
        end
        else
        begin
            item.kind = latched_reg ? KIND_TRACK : KIND_LATCH;
        end
        item.sum_x = {1'b0, x1} + {1'b0, x2};
        item.sum_y = {1'b0, y1} + {1'b0, y2};
        item.dx    = $signed({1'b0, x2}) - $signed({1'b0, x1});
        item.dy    = $signed({1'b0, y2}) - $signed({1'b0, y1});

        in_ready = !queue_full;
        push     = in_valid && !queue_full;

        prev_touch_next = prev_touch_reg;
        latched_next    = latched_reg;
        if (push)
        begin
            prev_touch_next = touch;
            if (touch)
            begin
                latched_next = 1'b1;
            end
            else if (changed)
            begin
                latched_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_touch_reg <= 1'b0;
            latched_reg    <= 1'b0;
        end
        else
        begin
            prev_touch_reg <= prev_touch_next;
            latched_reg    <= latched_next;
        end
    end

endmodule

@@ rtl/tgt_fifo.sv @@
// Short frame queue between the front and back ends of the gesture tracker.
// Register-based ring buffer with a fill count; no package dependencies.
module tgt_fifo #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    always_comb
    begin
        full     = (count_reg == CW'(DEPTH));
        empty    = (count_reg == '0);
        pop_data = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");

endmodule

@@ rtl/tgt_cordic.sv @@
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
// Gives dot distance (Q11.4) and angle (Q4.12 radians); depends on tgt_pkg.
module tgt_cordic
    import tgt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [DELTA_W-1:0] dx,
    input  logic signed [DELTA_W-1:0] dy,
    output logic                      done,
    output logic [DIST_W-1:0]         radius,
    output logic signed [ANG_W-1:0]   ang
);

    localparam int IW     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PROD_W = (XW - 1) + INVK_W;
    localparam int DFULL_W = PROD_W - 42;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_ITER = 2'd1;
    localparam logic [1:0] C_MUL  = 2'd2;
    localparam logic [1:0] C_DONE = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [IW-1:0]           iter_reg;
    logic [IW-1:0]           iter_next;
    logic signed [XW-1:0]    x_reg;
    logic signed [XW-1:0]    y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic                    zero_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic signed [XW-1:0]    x0;
    logic signed [XW-1:0]    y0;
    logic signed [ZW-1:0]    z0;
    logic signed [XW-1:0]    xs;
    logic signed [XW-1:0]    ys;
    logic signed [XW-1:0]    x_step;
    logic signed [XW-1:0]    y_step;
    logic signed [ZW-1:0]    z_step;
    logic signed [ZW-1:0]    atan_z;
    logic [XW-2:0]           x_clamp;
    logic [PROD_W-1:0]       prod_next;
    logic [PROD_W-1:0]       prod_rnd;
    logic [DFULL_W-1:0]      dist_full;
    logic signed [ZW-1:0]    z_rnd;

    always_comb
    begin
        x0 = XW'(dx) <<< PRE_SHIFT;
        y0 = XW'(dy) <<< PRE_SHIFT;
        z0 = '0;
        if (dx < 0)
        begin
            x0 = -x0;
            y0 = -y0;
            z0 = (dy >= 0) ? PI_Q30 : -PI_Q30;
        end

        xs     = x_reg >>> iter_reg;
        ys     = y_reg >>> iter_reg;
        atan_z = $signed({{(ZW - ATAN_W){1'b0}}, atan_q30(5'(iter_reg))});
        if (y_reg >= 0)
        begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + atan_z;
        end
        else
        begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - atan_z;
        end

        x_clamp   = x_reg[XW-1] ? '0 : x_reg[XW-2:0];
        prod_next = PROD_W'(x_clamp) * PROD_W'(INVK_Q30);

        prod_rnd  = prod_reg + (PROD_W'(1) << 41);
        dist_full = prod_rnd[PROD_W-1:42];
        z_rnd     = z_reg + (ZW'(1) << 17);

        done = (state_reg == C_DONE);
        if (zero_reg)
        begin
            radius = '0;
            ang    = '0;
        end
        else
        begin
            radius = (dist_full > DFULL_W'(32767)) ? {DIST_W{1'b1}} : dist_full[DIST_W-1:0];
            ang    = z_rnd[ANG_W+17:18];
        end

        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_ITER;
                    iter_next  = '0;
                end
            end
            C_ITER:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IW'(CORDIC_STEPS - 1))
                begin
                    state_next = C_MUL;
                end
            end
            C_MUL:
            begin
                state_next = C_DONE;
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            zero_reg <= (dx == 0) && (dy == 0);
        end
        else if (state_reg == C_ITER)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
        if (state_reg == C_MUL)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == C_IDLE)
        else $error("CORDIC started while busy");

endmodule

@@ rtl/tgt_back.sv @@
// Back end of the gesture tracker: runs CORDIC, forms the axis deltas and
// holds the start latch and the output register. Depends on tgt_pkg, tgt_cordic.
module tgt_back
    import tgt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  frame_t      q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_user,
    output logic [63:0] out_data
);

    localparam int DIFF_W   = 17;
    localparam int NW       = DIFF_W + FRAC_BITS;
    localparam int PY_PRE   = 8;
    localparam int TW       = NW - PY_PRE;
    localparam int RECIP_W  = 22;
    localparam int DIV3_SH  = 23;
    localparam int QPROD_W  = TW + RECIP_W;
    localparam int PX_SH    = 10;
    localparam int PN_SH    = 13;

    localparam logic [RECIP_W-1:0] DIV3_RECIP = 22'd2796203;
    localparam logic [NW-1:0]      PY_HALF    = NW'(384);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_CORD  = 3'd1;
    localparam logic [2:0] B_CALC  = 3'd2;
    localparam logic [2:0] B_DIV   = 3'd3;
    localparam logic [2:0] B_WRITE = 3'd4;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    frame_t                    cur_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic signed [ANG_W-1:0]   ang_reg;
    logic [AXIS_W-1:0]         px_reg;
    logic [AXIS_W-1:0]         py_reg;
    logic [AXIS_W-1:0]         pn_reg;
    logic [AXIS_W-1:0]         tw_reg;
    logic [TW-1:0]             t_reg;
    logic                      tneg_reg;
    logic [SUM_W-1:0]          start_sx_reg;
    logic [SUM_W-1:0]          start_sy_reg;
    logic [DIST_W-1:0]         start_dist_reg;
    logic signed [ANG_W-1:0]   start_ang_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [2:0]                out_user_reg;
    logic [63:0]               out_data_reg;

    logic                      cord_start;
    logic                      cord_done;
    logic [DIST_W-1:0]         cord_dist;
    logic signed [ANG_W-1:0]   cord_ang;

    logic signed [DIFF_W-1:0]  dsx;
    logic signed [DIFF_W-1:0]  dsy;
    logic signed [DIFF_W-1:0]  ddist;
    logic signed [DIFF_W-1:0]  dang;
    logic [NW-1:0]             msy;
    logic [NW-1:0]             tsum;
    logic [QPROD_W-1:0]        qprod;
    logic [QPROD_W-DIV3_SH-1:0] q3;
    logic                      load;
    logic                      tracked;

    function automatic logic [NW-1:0] mag_scaled(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] m;
        begin
            m = v[DIFF_W-1] ? -v : v;
            return NW'(m) << FRAC_BITS;
        end
    endfunction

    function automatic logic [NW-1:0] round_shift(input logic [NW-1:0] m, input int k);
        logic [NW-1:0] s;
        begin
            s = m + (NW'(1) << (k - 1));
            return s >> k;
        end
    endfunction

    function automatic logic [AXIS_W-1:0] sat16(input logic neg, input logic [NW-1:0] m);
        logic [AXIS_W-1:0] r;
        begin
            if (!neg)
            begin
                r = (m > NW'(32767)) ? 16'h7FFF : m[AXIS_W-1:0];
            end
            else
            begin
                r = (m > NW'(32768)) ? 16'h8000 : 16'h0000 - m[AXIS_W-1:0];
            end
            return r;
        end
    endfunction

    tgt_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cord_start),
        .dx     (q_data.dx),
        .dy     (q_data.dy),
        .done   (cord_done),
        .radius (cord_dist),
        .ang    (cord_ang)
    );

    always_comb
    begin
        dsx   = $signed({6'b0, cur_reg.sum_x}) - $signed({6'b0, start_sx_reg});
        dsy   = $signed({6'b0, cur_reg.sum_y}) - $signed({6'b0, start_sy_reg});
        ddist = $signed({2'b0, dist_reg}) - $signed({2'b0, start_dist_reg});
        dang  = DIFF_W'(ang_reg) - DIFF_W'(start_ang_reg);
        msy   = mag_scaled(dsy);
        tsum  = (msy + PY_HALF) >> PY_PRE;
        qprod = QPROD_W'(t_reg) * QPROD_W'(DIV3_RECIP);
        q3    = qprod[QPROD_W-1:DIV3_SH];

        tracked = (q_data.kind == KIND_LATCH) || (q_data.kind == KIND_TRACK);
        q_pop      = (state_reg == B_IDLE) && !q_empty;
        cord_start = q_pop && tracked;
        load       = (state_reg == B_WRITE) && (!out_valid_reg || out_ready);

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = tracked ? B_CORD : B_WRITE;
                end
            end
            B_CORD:
            begin
                if (cord_done)
                begin
                    state_next = B_CALC;
                end
            end
            B_CALC:
            begin
                state_next = B_DIV;
            end
            B_DIV:
            begin
                state_next = B_WRITE;
            end
            B_WRITE:
            begin
                if (load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_valid = out_valid_reg;
        out_user  = out_user_reg;
        out_data  = out_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (state_reg == B_CORD && cord_done)
        begin
            dist_reg <= cord_dist;
            ang_reg  <= cord_ang;
        end
        if (state_reg == B_CALC)
        begin
            px_reg   <= sat16(dsx[DIFF_W-1], round_shift(mag_scaled(dsx), PX_SH));
            pn_reg   <= sat16(ddist[DIFF_W-1], round_shift(mag_scaled(ddist), PN_SH));
            tw_reg   <= sat16(dang[DIFF_W-1], round_shift(mag_scaled(dang), PN_SH));
            t_reg    <= tsum[TW-1:0];
            tneg_reg <= dsy[DIFF_W-1];
        end
        if (state_reg == B_DIV)
        begin
            py_reg <= sat16(tneg_reg, NW'(q3));
        end
        if (load)
        begin
            out_user_reg <= {(cur_reg.kind == KIND_RELEASE) || (cur_reg.kind == KIND_TRACK),
                             cur_reg.changed, cur_reg.touch};
            if (cur_reg.kind == KIND_TRACK)
            begin
                out_data_reg <= {tw_reg, pn_reg, py_reg, px_reg};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            out_valid_reg  <= 1'b0;
            start_sx_reg   <= '0;
            start_sy_reg   <= '0;
            start_dist_reg <= '0;
            start_ang_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load && cur_reg.kind == KIND_LATCH)
            begin
                start_sx_reg   <= cur_reg.sum_x;
                start_sy_reg   <= cur_reg.sum_y;
                start_dist_reg <= dist_reg;
                start_ang_reg  <= ang_reg;
            end
        end
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cord_done |-> state_reg == B_CORD)
        else $error("CORDIC result arrived outside the wait state");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg && state_reg == B_IDLE)
        else $error("result transaction not presented after load");

endmodule

@@ rtl/two_point_gesture_tracker.sv @@
// Top level of the two-point pan / pinch / twist gesture tracker.
// Joins tgt_front, tgt_fifo and tgt_back; depends on tgt_pkg.
//
//   channel  dir  tdata (low bit up)                  tuser (low bit up)
//   s_*      in   first_x, first_y, second_x,         first_visible,
//                 second_y (10 b each, 40 b)          second_visible
//   m_*      out  pan_x, pan_y, pinch, twist          touch, touch_changed,
//                 (16 b signed each, 64 b)            axes_valid
//
// A touched frame steps the back end through B_CORD, B_CALC, B_DIV and B_WRITE,
// paced by the one-rotation-per-cycle CORDIC loop; other frames go to B_WRITE directly.
// The front end accepts a frame per cycle until the QUEUE_DEPTH-entry queue fills.
// Reset is asynchronous, active low, and clears the touch and start latches.
// A stalled m_tready holds the result; the queue keeps taking frames until it fills.
module two_point_gesture_tracker
    import tgt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 13,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // first_x, first_y, second_x, second_y
    input  logic [1:0]  s_tuser,   // first_visible, second_visible
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pan_x, pan_y, pinch, twist
    output logic [2:0]  m_tuser    // touch, touch_changed, axes_valid
);

    frame_t push_item;
    frame_t pop_item;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    tgt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_user    (s_tuser),
        .queue_full (full),
        .push       (push),
        .item       (push_item)
    );

    tgt_fifo #(
        .WIDTH ($bits(frame_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_item),
        .empty     (empty)
    );

    tgt_back #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_data    (pop_item),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_user  (m_tuser),
        .out_data  (m_tdata)
    );

endmodule

@@ test/tb_two_point_gesture_tracker.sv @@
// Self-checking testbench for the two-point gesture tracker: directed frames, then random
// gestures and noise under changing handshake idling, checked against an in-bench predictor.
// Depends on tgt_pkg and two_point_gesture_tracker.
module tb_two_point_gesture_tracker
    import tgt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     N_STEPS       = 16;
    localparam int     AXIS_FRAC     = 13;
    localparam int     ANGLE_FRAC    = 12;
    localparam longint HALF_TURN_Q30 = 64'd3373259426;
    localparam longint GAIN_INV_Q30  = 64'd652032874;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     DRAIN_CYCLES   = 60;
    localparam int     TOTAL_FRAMES   = 550;

    localparam longint ARCTAN_Q30 [0:15] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6,
        'h03FEAB76, 'h01FFD55B, 'h00FFFAAA, 'h007FFF55,
        'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF
    };

    typedef struct packed {
        logic               touch;
        logic               touch_changed;
        logic               axes_valid;
        logic signed [15:0] pan_x;
        logic signed [15:0] pan_y;
        logic signed [15:0] pinch;
        logic signed [15:0] twist;
    } gesture_report_t;

    class gesture_scoreboard;
        gesture_report_t          expected_reports[$];
        bit                       was_touched;
        bit                       start_held;
        logic [SUM_W-1:0]         start_sum_x;
        logic [SUM_W-1:0]         start_sum_y;
        logic [DIST_W-1:0]        start_dist;
        logic signed [ANG_W-1:0]  start_ang;
        int                       mismatches;
        int                       reports_checked;

        function new();
            was_touched = 0;
            start_held = 0;
            start_sum_x = '0;
            start_sum_y = '0;
            start_dist = '0;
            start_ang = '0;
            mismatches = 0;
            reports_checked = 0;
        endfunction

        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function logic signed [15:0] clamp16(longint v);
            if (v > 32767)
                return 16'sd32767;
            if (v < -32768)
                return 16'sh8000;
            return v[15:0];
        endfunction

        function void polar(input longint dx, input longint dy,
                            output longint span, output longint ang);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            longint unsigned d;
            if (dx == 0 && dy == 0)
            begin
                span = 0;
                ang = 0;
                return;
            end
            x = dx * 65536;
            y = dy * 65536;
            z = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = (dy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
            end
            for (int i = 0; i < N_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARCTAN_Q30[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARCTAN_Q30[i];
                end
            end
            if (x < 0)
                x = 0;
            d = (longint'(x) * GAIN_INV_Q30 + (longint'(1) << 41)) >> 42;
            if (d > 32767)
                d = 32767;
            span = longint'(d);
            ang = (z + (longint'(1) << 17)) >>> 18;
        endfunction

        function void note_frame(bit fv, logic [9:0] x1, logic [9:0] y1,
                                 bit sv, logic [9:0] x2, logic [9:0] y2);
            gesture_report_t r;
            bit              touched;
            longint          sx;
            longint          sy;
            longint          span;
            longint          ang;
            longint          da;
            touched = fv & sv;
            r = '0;
            r.touch = touched;
            r.touch_changed = (touched != was_touched);
            if (r.touch_changed && !touched)
            begin
                r.axes_valid = 1'b1;
                start_held = 0;
            end
            if (touched)
            begin
                sx = longint'(x1) + longint'(x2);
                sy = longint'(y1) + longint'(y2);
                polar(longint'(x2) - longint'(x1), longint'(y2) - longint'(y1), span, ang);
                if (!start_held)
                begin
                    start_held = 1;
                    start_sum_x = sx[SUM_W-1:0];
                    start_sum_y = sy[SUM_W-1:0];
                    start_dist = span[DIST_W-1:0];
                    start_ang = ang[ANG_W-1:0];
                end
                else
                begin
                    da = ang - longint'(start_ang);
                    r.axes_valid = 1'b1;
                    r.pan_x = clamp16(round_div((sx - longint'(start_sum_x)) <<< AXIS_FRAC, 1024));
                    r.pan_y = clamp16(round_div((sy - longint'(start_sum_y)) <<< AXIS_FRAC, 768));
                    r.pinch = clamp16(round_div((span - longint'(start_dist)) <<< AXIS_FRAC,
                                                8192));
                    r.twist = clamp16(da <<< (AXIS_FRAC - 1 - ANGLE_FRAC));
                end
            end
            was_touched = touched;
            expected_reports.push_back(r);
        endfunction

        function void check_report(gesture_report_t got);
            gesture_report_t want;
            reports_checked++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: touch=%0b chg=%0b valid=%0b %0d %0d %0d %0d",
                             got.touch, got.touch_changed, got.axes_valid,
                             got.pan_x, got.pan_y, got.pinch, got.twist);
                return;
            end
            want = expected_reports.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("report %0d expected: touch=%0b chg=%0b valid=%0b pan=%0d,%0d pinch=%0d twist=%0d",
                             reports_checked, want.touch, want.touch_changed, want.axes_valid,
                             want.pan_x, want.pan_y, want.pinch, want.twist);
                    $display("report %0d actual:   touch=%0b chg=%0b valid=%0b pan=%0d,%0d pinch=%0d twist=%0d",
                             reports_checked, got.touch, got.touch_changed, got.axes_valid,
                             got.pan_x, got.pan_y, got.pinch, got.twist);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;

    gesture_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int frames_sent;
    int results_seen;
    int quiet_cycles;
    bit long_hold_done;

    two_point_gesture_tracker u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        gesture_report_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_frame(s_tuser[0], s_tdata[9:0], s_tdata[19:10],
                              s_tuser[1], s_tdata[29:20], s_tdata[39:30]);
            if (m_tvalid && m_tready)
            begin
                got.touch = m_tuser[0];
                got.touch_changed = m_tuser[1];
                got.axes_valid = m_tuser[2];
                got.pan_x = m_tdata[15:0];
                got.pan_y = m_tdata[31:16];
                got.pinch = m_tdata[47:32];
                got.twist = m_tdata[63:48];
                sb.check_report(got);
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold once traffic is flowing
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && results_seen >= 30)
            begin
                long_hold_done = 1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_frame(bit fv, int x1, int y1, bit sv, int x2, int y2);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = {sv, fv};
        s_tdata = {y2[9:0], x2[9:0], y1[9:0], x1[9:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        frames_sent++;
    endtask

    function automatic int pick_y();
        return ($urandom_range(9) == 0) ? $urandom_range(1023, 768) : $urandom_range(767);
    endfunction

    function automatic int walk(int v, int hi);
        int n;
        if ($urandom_range(9) == 0)
            return $urandom_range(hi);
        n = v + $urandom_range(80) - 40;
        if (n < 0)
            n = 0;
        if (n > hi)
            n = hi;
        return n;
    endfunction

    task automatic send_gesture(int len);
        int  x1;
        int  y1;
        int  x2;
        int  y2;
        bit  fv;
        bit  sv;
        x1 = $urandom_range(1023);
        y1 = pick_y();
        x2 = $urandom_range(1023);
        y2 = pick_y();
        if ($urandom_range(7) == 0)
        begin
            x2 = x1;
            y2 = ($urandom_range(1) == 0) ? y1 : y1 + 1;
        end
        repeat (len)
        begin
            send_frame(1'b1, x1, y1, 1'b1, x2, y2);
            x1 = walk(x1, 1023);
            y1 = walk(y1, 1023);
            x2 = walk(x2, 1023);
            y2 = walk(y2, 1023);
        end
        {fv, sv} = 2'($urandom_range(2));
        send_frame(fv, x1, y1, sv, x2, y2);
    endtask

    task automatic send_noise();
        send_frame(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                   1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic run_random(int upto);
        while (frames_sent < upto)
        begin
            if ($urandom_range(4) == 0)
                send_noise();
            else
                send_gesture($urandom_range(12, 2));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        tx_idle_pct = 6;
        rx_idle_pct = 50;
        frames_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        long_hold_done = 0;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_frame(0, 0, 0, 0, 0, 0);
        send_frame(1, 0, 0, 0, 1023, 767);
        send_frame(1, 0, 0, 1, 1023, 767);
        send_frame(1, 0, 0, 1, 1023, 767);
        send_frame(1, 1023, 767, 1, 0, 0);
        send_frame(1, 1023, 1023, 1, 1023, 1023);
        send_frame(1, 0, 0, 1, 0, 0);
        send_frame(0, 0, 0, 1, 0, 0);
        send_frame(0, 0, 0, 1, 500, 300);
        send_frame(1, 800, 300, 1, 100, 300);
        send_frame(1, 100, 300, 1, 800, 300);
        send_frame(1, 100, 301, 1, 800, 300);
        send_frame(1, 800, 300, 1, 100, 301);
        send_frame(1, 800, 301, 1, 100, 300);
        send_frame(0, 0, 0, 0, 0, 0);
        send_frame(0, 1023, 1023, 0, 1023, 1023);
        send_frame(1, 512, 384, 1, 512, 384);
        send_frame(1, 0, 0, 1, 1023, 767);
        send_frame(1, 1023, 0, 1, 0, 767);
        send_frame(1, 5, 7, 0, 9, 9);
        send_frame(1, 1, 1, 1, 1, 2);
        send_frame(1, 1, 2, 1, 1, 1);
        send_frame(0, 1023, 767, 0, 1023, 767);

        run_random(190);
        tx_idle_pct = 50;
        rx_idle_pct = 6;
        run_random(370);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(TOTAL_FRAMES);

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d frames (directed, random gestures and noise) under three idling",
                 frames_sent);
        $display("profiles and a %0d-cycle output hold; %0d reports checked, %0d mismatched",
                 HOLD_CYCLES, sb.reports_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
